[sv/conv3x3_divide_abs_clamp_assert.svh]
// ---------------------------------------------------------------------------
// conv3x3_divide_abs_clamp assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef CONV3X3_DIVIDE_ABS_CLAMP_ASSERT_SVH
`define CONV3X3_DIVIDE_ABS_CLAMP_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define C3DAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent checked in the same cycle
`define C3DAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/c3dac_pkg.sv]
// ---------------------------------------------------------------------------
// c3dac_pkg
// types and constants of the 3x3 convolution block
// ---------------------------------------------------------------------------
package c3dac_pkg;

  localparam int PIX_W     = 8;
  localparam int TAP_W     = 8;
  localparam int KROW_W    = 3 * TAP_W;
  localparam int DIVR_W    = 8;
  localparam int FW_W      = 9;
  localparam int FH_W      = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = KROW_W;
  localparam int ROW_OUT_W = 12;
  localparam int COL_OUT_W = 8;
  localparam int SUM_W     = 20;
  localparam int MAG_W     = SUM_W - 1;
  localparam int DIV_CNT_W = $clog2(MAG_W + 1);
  localparam int NUM_TAPS  = 9;
  localparam int PIX_MAX   = 255;

  localparam logic [CFG_IDX_W-1:0] REG_KERN_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERN_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERN_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FWIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FHEIGHT  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAUNCH,
    ST_MAC,
    ST_DIV,
    ST_EMIT,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum;
  } mac_link_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [DIVR_W-1:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/c3dac_if.sv]
// ---------------------------------------------------------------------------
// c3dac channel interfaces
// pixel input channel and result output channel
// ---------------------------------------------------------------------------
interface c3dac_in_if;
  import c3dac_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface c3dac_out_if;
  import c3dac_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ROW_OUT_W-1:0] out_row;
  logic [COL_OUT_W-1:0] out_col;
  logic [PIX_W-1:0]     out_value;
  logic                 last_of_run;
  modport source (output valid, output out_row, output out_col, output out_value,
                  output last_of_run, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input last_of_run, output ready);
endinterface

[sv/c3dac_mac_cell.sv]
// ---------------------------------------------------------------------------
// c3dac_mac_cell
// one tap of the multiply-accumulate chain
// ---------------------------------------------------------------------------
module c3dac_mac_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [c3dac_pkg::TAP_W-1:0] tap,
  input  logic [c3dac_pkg::PIX_W-1:0] pix,
  input  c3dac_pkg::mac_link_t        link_in,
  output c3dac_pkg::mac_link_t        link_out
);
  import c3dac_pkg::*;

  logic                    valid_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [TAP_W+PIX_W:0] prod;

  assign prod    = $signed(tap) * $signed({1'b0, pix});
  assign sum_nxt = link_in.sum + SUM_W'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.valid) begin
      sum_r <= sum_nxt;
    end
  end

  assign link_out.valid = valid_r;
  assign link_out.sum   = sum_r;
endmodule

[sv/c3dac_divider.sv]
// ---------------------------------------------------------------------------
// c3dac_divider
// restoring divider, one quotient bit a cycle, truncates toward zero
// ---------------------------------------------------------------------------
module c3dac_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  c3dac_pkg::div_req_t req,
  output c3dac_pkg::div_rsp_t rsp
);
  import c3dac_pkg::*;

  logic                    busy_r;
  logic                    done_r;
  logic [DIV_CNT_W-1:0]    cnt_r;
  logic [DIVR_W-1:0]       dvs_r;
  logic [DIVR_W-1:0]       rem_r;
  logic [MAG_W-1:0]        quo_r;
  logic                    neg_r;
  logic signed [SUM_W-1:0] res_r;

  logic [SUM_W-1:0]  mag;
  logic [DIVR_W:0]   trial;
  logic              qbit;
  logic [DIVR_W-1:0] rem_nxt;
  logic [MAG_W-1:0]  quo_nxt;

  always_comb begin
    mag     = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
    trial   = {rem_r, quo_r[MAG_W-1]};
    qbit    = trial >= {1'b0, dvs_r};
    rem_nxt = qbit ? DIVR_W'(trial - {1'b0, dvs_r}) : DIVR_W'(trial);
    quo_nxt = {quo_r[MAG_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= (req.divisor != '0);
        done_r <= (req.divisor == '0);
      end else if (busy_r && cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs_r <= req.divisor;
      neg_r <= req.dividend[SUM_W-1];
      quo_r <= mag[MAG_W-1:0];
      rem_r <= '0;
      cnt_r <= DIV_CNT_W'(MAG_W);
      res_r <= req.dividend;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        res_r <= neg_r ? -$signed({1'b0, quo_nxt}) : $signed({1'b0, quo_nxt});
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = res_r;
endmodule

[sv/conv3x3_divide_abs_clamp.sv]
// ---------------------------------------------------------------------------
// conv3x3_divide_abs_clamp
// 3x3 convolution with divide, abs and clamp on a raster pixel stream
// ---------------------------------------------------------------------------
// One pixel is taken at a time; the input stays closed while it goes through the
// read, launch, multiply-accumulate, divide, emit and update states, and the emit
// state waits on the output side for each result (up to four). The wait is set
// by the nine-cell multiply-accumulate chain that the partial sum walks through
// and by the divider: one quotient bit per cycle over 19 bits, none for divisor 0.
// Line stores are not cleared after reset; feed each frame from row 0.
module conv3x3_divide_abs_clamp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  c3dac_in_if.sink                        in_if,
  c3dac_out_if.source                     out_if,
  input  logic                            cfg_we,
  input  logic [c3dac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [c3dac_pkg::CFG_DAT_W-1:0] cfg_data
);
  import c3dac_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  localparam int SLOT_MAIN   = 0;
  localparam int SLOT_ROWEND = 1;
  localparam int SLOT_BOTTOM = 2;
  localparam int SLOT_CORNER = 3;

  // configuration
  logic [KROW_W-1:0] kern_r [3];
  logic [DIVR_W-1:0] divisor_r;
  logic              abs_r;
  logic [FW_W-1:0]   fw_r;
  logic [FH_W-1:0]   fh_r;

  state_t state_r, state_nxt;

  logic [CW-1:0]    col_r;
  logic [RW-1:0]    row_r;
  logic [CW-1:0]    c_r;
  logic [RW-1:0]    r_r;
  logic [PIX_W-1:0] px_r, up_r, mid_r;
  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [PIX_W-1:0] filt_r;
  logic             interior_r;
  logic [3:0]       mask_r;

  logic                 o_valid_r;
  logic [ROW_OUT_W-1:0] o_row_r;
  logic [COL_OUT_W-1:0] o_col_r;
  logic [PIX_W-1:0]     o_val_r;
  logic                 o_last_r;

  logic [CW:0] w_eff, wm1;
  logic [RW:0] h_eff, hm1;
  logic [CW:0] c_a, c_n;
  logic [RW:0] r_a, r_n;

  logic in_acc, mac_go, div_start, emit_load, out_free;
  logic [3:0] mask_rest;
  logic [RW-1:0] e_row;
  logic [CW-1:0] e_col;
  logic [PIX_W-1:0] e_val;

  mac_link_t        link [NUM_TAPS+1];
  logic [PIX_W-1:0] nbr  [NUM_TAPS];
  div_req_t         dreq;
  div_rsp_t         drsp;

  logic signed [SUM_W-1:0] qa;
  logic [PIX_W-1:0]        filt;
  logic [3:0]              mask_new;

  // ---- configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_r[0] <= '0;
      kern_r[1] <= KROW_W'(256);
      kern_r[2] <= '0;
      divisor_r <= DIVR_W'(1);
      abs_r     <= 1'b0;
      fw_r      <= FW_W'(256);
      fh_r      <= FH_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KERN_TOP: kern_r[0] <= cfg_data;
        REG_KERN_MID: kern_r[1] <= cfg_data;
        REG_KERN_BOT: kern_r[2] <= cfg_data;
        REG_DIVISOR:  divisor_r <= cfg_data[DIVR_W-1:0];
        REG_ABS_MODE: abs_r     <= cfg_data[0];
        REG_FWIDTH:   fw_r      <= cfg_data[FW_W-1:0];
        REG_FHEIGHT:  fh_r      <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- frame size in use and position of the arriving pixel
  always_comb begin
    if (fw_r < FW_W'(3)) begin
      w_eff = (CW+1)'(3);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(fw_r);
    end
    if (fh_r < FH_W'(3)) begin
      h_eff = (RW+1)'(3);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(fh_r);
    end
    wm1 = w_eff - (CW+1)'(1);
    hm1 = h_eff - (RW+1)'(1);

    c_a = in_if.frame_start ? '0 : {1'b0, col_r};
    r_a = in_if.frame_start ? '0 : {1'b0, row_r};
    if (c_a >= w_eff) begin
      c_a = '0;
      r_a = r_a + (RW+1)'(1);
    end
    if (r_a >= h_eff) begin
      r_a = '0;
    end
    c_n = c_a + (CW+1)'(1);
    r_n = r_a;
    if (c_n >= w_eff) begin
      c_n = '0;
      r_n = r_a + (RW+1)'(1);
      if (r_n >= h_eff) begin
        r_n = '0;
      end
    end
  end

  // ---- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_acc    = 1'b0;
    mac_go    = 1'b0;
    div_start = 1'b0;
    emit_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_acc = in_if.valid;
        if (in_if.valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_LAUNCH;
      ST_LAUNCH: begin
        mac_go    = 1'b1;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (link[NUM_TAPS].valid) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (mask_r == '0) begin
          state_nxt = ST_UPDATE;
        end else begin
          emit_load = out_free;
        end
      end
      ST_UPDATE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_if.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        col_r <= c_n[CW-1:0];
        row_r <= r_n[RW-1:0];
      end
      if (state_r == ST_UPDATE) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i] <= win_r[3+i];
        end
        win_r[3] <= up_r;
        win_r[4] <= mid_r;
        win_r[5] <= px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      c_r  <= c_a[CW-1:0];
      r_r  <= r_a[RW-1:0];
      px_r <= in_if.pixel;
    end
  end

  // ---- line stores
  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      up_r  <= upper_mem[c_r];
      mid_r <= middle_mem[c_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      upper_mem[c_r]  <= mid_r;
      middle_mem[c_r] <= px_r;
    end
  end

  // ---- multiply-accumulate chain over the window
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nbr[3*i]   = win_r[i];
      nbr[3*i+1] = win_r[3+i];
    end
    nbr[2] = up_r;
    nbr[5] = mid_r;
    nbr[8] = px_r;
  end

  assign link[0].valid = mac_go;
  assign link[0].sum   = '0;

  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
    c3dac_mac_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tap      (kern_r[k/3][TAP_W*(k%3) +: TAP_W]),
      .pix      (nbr[k]),
      .link_in  (link[k]),
      .link_out (link[k+1])
    );
  end

  assign dreq.start    = div_start;
  assign dreq.dividend = link[NUM_TAPS].sum;
  assign dreq.divisor  = divisor_r;

  c3dac_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // ---- abs, clamp and result selection
  always_comb begin
    qa = (abs_r && drsp.quotient < 0) ? -drsp.quotient : drsp.quotient;
    if (qa < 0) begin
      filt = '0;
    end else if (qa > SUM_W'(PIX_MAX)) begin
      filt = PIX_W'(PIX_MAX);
    end else begin
      filt = qa[PIX_W-1:0];
    end
    mask_new = '0;
    mask_new[SLOT_MAIN]   = (r_r != '0) && (c_r != '0);
    mask_new[SLOT_ROWEND] = (r_r != '0) && ({1'b0, c_r} == wm1);
    mask_new[SLOT_BOTTOM] = ({1'b0, r_r} == hm1) && (c_r != '0);
    mask_new[SLOT_CORNER] = ({1'b0, r_r} == hm1) && ({1'b0, c_r} == wm1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (state_r == ST_DIV && drsp.done) begin
      mask_r <= mask_new;
    end else if (emit_load) begin
      mask_r <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && drsp.done) begin
      filt_r     <= filt;
      interior_r <= (r_r >= RW'(2)) && (c_r >= CW'(2));
    end
  end

  // lowest pending slot goes out first
  always_comb begin
    mask_rest = mask_r;
    e_row     = r_r;
    e_col     = wm1[CW-1:0];
    e_val     = px_r;
    priority if (mask_r[SLOT_MAIN]) begin
      mask_rest[SLOT_MAIN] = 1'b0;
      e_row = r_r - RW'(1);
      e_col = c_r - CW'(1);
      e_val = interior_r ? filt_r : win_r[4];
    end else if (mask_r[SLOT_ROWEND]) begin
      mask_rest[SLOT_ROWEND] = 1'b0;
      e_row = r_r - RW'(1);
      e_val = mid_r;
    end else if (mask_r[SLOT_BOTTOM]) begin
      mask_rest[SLOT_BOTTOM] = 1'b0;
      e_col = c_r - CW'(1);
      e_val = win_r[5];
    end else begin
      mask_rest[SLOT_CORNER] = 1'b0;
    end
  end

  // ---- output register
  assign out_free = !o_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (emit_load) begin
      o_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      o_row_r  <= ROW_OUT_W'(e_row);
      o_col_r  <= COL_OUT_W'(e_col);
      o_val_r  <= e_val;
      o_last_r <= (mask_rest == '0);
    end
  end

  assign out_if.valid       = o_valid_r;
  assign out_if.out_row     = o_row_r;
  assign out_if.out_col     = o_col_r;
  assign out_if.out_value   = o_val_r;
  assign out_if.last_of_run = o_last_r;
endmodule

[sv/c3dac_checker.sv]
// ---------------------------------------------------------------------------
// c3dac_checker
// port-level checks of the convolution block
// ---------------------------------------------------------------------------
`include "conv3x3_divide_abs_clamp_assert.svh"

module c3dac_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  // a stalled result stays offered
  `C3DAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  // one item at a time: no second pixel right after an accepted one
  `C3DAC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "pixel taken while busy")
  // results of one item still pending keep the input closed
  `C3DAC_ASSERT_NEXT(a_run_open, out_valid && out_ready && !out_last, !in_ready,
                     "input opened inside a run")
  // input never opens while a non-final result waits
  `C3DAC_ASSERT_SAME(a_run_wait, out_valid && !out_last, !in_ready,
                     "input open with run pending")
endmodule

bind conv3x3_divide_abs_clamp c3dac_checker u_c3dac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_last  (out_if.last_of_run)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// pixel streams of random sizes and kernels into the 3x3 convolution block;
// every result is checked against an in-bench model of the window filter
// ---------------------------------------------------------------------------
import c3dac_pkg::*;

typedef struct {
  logic [ROW_OUT_W-1:0] row;
  logic [COL_OUT_W-1:0] col;
  logic [PIX_W-1:0]     value;
  logic                 last;
} pix_result_t;

class conv_scoreboard;
  logic [KROW_W-1:0] krow[3];
  logic [DIVR_W-1:0] divr;
  logic              absm;
  int unsigned       fw, fh;
  logic [7:0]        upper[256];
  logic [7:0]        middle[256];
  logic [7:0]        win[6];
  int unsigned       rowc, colc;
  pix_result_t       pending[$];
  int                errors;

  function new();
    krow[0] = '0;
    krow[1] = 24'h000100;
    krow[2] = '0;
    divr = 8'd1;
    absm = 1'b0;
    fw = 256;
    fh = 256;
    foreach (upper[i]) begin
      upper[i] = '0;
      middle[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    rowc = 0;
    colc = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    case (idx)
      REG_KERN_TOP: krow[0] = d;
      REG_KERN_MID: krow[1] = d;
      REG_KERN_BOT: krow[2] = d;
      REG_DIVISOR:  divr = d[DIVR_W-1:0];
      REG_ABS_MODE: absm = d[0];
      REG_FWIDTH:   fw = d[FW_W-1:0];
      REG_FHEIGHT:  fh = d[FH_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [7:0] filtered(logic [7:0] up, logic [7:0] mid, logic [7:0] px);
    int sum;
    int pix[3][3];
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      pix[i][0] = win[i];
      pix[i][1] = win[3 + i];
    end
    pix[0][2] = up;
    pix[1][2] = mid;
    pix[2][2] = px;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        sum += int'($signed(krow[i][8*j +: 8])) * pix[i][j];
    // integer division truncates toward zero
    if (divr != 0) sum = sum / int'(divr);
    if (absm && sum < 0) sum = -sum;
    if (sum < 0) sum = 0;
    if (sum > PIX_MAX) sum = PIX_MAX;
    return sum[7:0];
  endfunction

  function void push_result(int unsigned r, int unsigned c, logic [7:0] v);
    pix_result_t e;
    e.row = r[ROW_OUT_W-1:0];
    e.col = c[COL_OUT_W-1:0];
    e.value = v;
    e.last = 1'b0;
    pending.push_back(e);
  endfunction

  function void note_pixel(logic [7:0] px, logic fs);
    int unsigned w, h, r, c, n;
    logic [7:0] up, mid;
    w = (fw < 3) ? 3 : (fw > 256) ? 256 : fw;
    h = (fh < 3) ? 3 : (fh > 4096) ? 4096 : fh;
    n = 0;
    if (fs) begin
      rowc = 0;
      colc = 0;
    end
    // position past a shrunken size wraps
    if (colc >= w) begin
      colc = 0;
      rowc++;
    end
    if (rowc >= h) rowc = 0;
    r = rowc;
    c = colc;
    up = upper[c];
    mid = middle[c];
    if (r >= 1 && c >= 1) begin
      if (r - 1 >= 1 && r - 1 <= h - 2 && c - 1 >= 1 && c - 1 <= w - 2)
        push_result(r - 1, c - 1, filtered(up, mid, px));
      else
        push_result(r - 1, c - 1, win[4]);
      n++;
    end
    if (r >= 1 && c == w - 1) begin
      push_result(r - 1, w - 1, mid);
      n++;
    end
    if (r == h - 1 && c >= 1) begin
      push_result(r, c - 1, win[5]);
      n++;
    end
    if (r == h - 1 && c == w - 1) begin
      push_result(r, w - 1, px);
      n++;
    end
    if (n > 0) pending[pending.size() - 1].last = 1'b1;
    upper[c] = mid;
    middle[c] = px;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = up;
    win[4] = mid;
    win[5] = px;
    colc = c + 1;
    if (colc >= w) begin
      colc = 0;
      rowc = r + 1;
      if (rowc >= h) rowc = 0;
    end
  endfunction

  function void check(logic [ROW_OUT_W-1:0] row, logic [COL_OUT_W-1:0] col,
                      logic [PIX_W-1:0] value, logic last);
    pix_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result row %0d col %0d value %0d", $time, row, col, value);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (row !== e.row) begin
      $display("%0t: out_row expected %0d actual %0d", $time, e.row, row);
      errors++;
    end
    if (col !== e.col) begin
      $display("%0t: out_col expected %0d actual %0d", $time, e.col, col);
      errors++;
    end
    if (value !== e.value) begin
      $display("%0t: out_value at (%0d,%0d) expected %0d actual %0d",
               $time, e.row, e.col, e.value, value);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t: last_of_run at (%0d,%0d) expected %0d actual %0d",
               $time, e.row, e.col, e.last, last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  c3dac_in_if  pix_ch();
  c3dac_out_if res_ch();

  conv3x3_divide_abs_clamp DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (pix_ch),
    .out_if    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  conv_scoreboard sb = new();

  int  burst_left;
  bit  gaps_on;
  int  stall_mode;
  int  cyc;
  int  items_sent;
  int  cur_w, cur_h;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    cyc <= cyc + 1;
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= 1'($urandom_range(0, 1));
      2: res_ch.ready <= (cyc % 5) != 0;
      default: res_ch.ready <= ((cyc / 7) % 3) != 0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready)
      sb.check(res_ch.out_row, res_ch.out_col, res_ch.out_value, res_ch.last_of_run);
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, d);
    if (idx == REG_FWIDTH) cur_w = (d < 3) ? 3 : (d > 256) ? 256 : d;
    if (idx == REG_FHEIGHT) cur_h = (d < 3) ? 3 : (d > 4096) ? 4096 : d;
  endtask

  task automatic send_pixel(logic [7:0] px, logic fs);
    if (burst_left == 0) begin
      if (gaps_on) begin
        pix_ch.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    pix_ch.valid = 1'b1;
    pix_ch.pixel = px;
    pix_ch.frame_start = fs;
    do @(posedge clk); while (!pix_ch.ready);
    sb.note_pixel(px, fs);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  // block may still be busy on an item with no result after the queue drains
  task automatic wait_idle();
    pix_ch.valid = 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frames(int count, bit noise);
    for (int k = 0; k < count; k++)
      send_pixel(8'($urandom_range(0, 255)),
                 k == 0 || (noise && $urandom_range(0, 99) < 3));
  endtask

  initial begin
    int n, w_sel, h_sel, prev_w;
    bit cont;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    pix_ch.frame_start = 1'b0;
    res_ch.ready = 1'b0;
    cyc = 0;
    stall_mode = 0;
    burst_left = 0;
    gaps_on = 1'b0;
    items_sent = 0;
    cur_w = 256;
    cur_h = 256;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: identity kernel on a minimal frame with extreme pixels
    write_cfg(REG_FWIDTH, 3);
    write_cfg(REG_FHEIGHT, 3);
    for (int k = 0; k < 9; k++) send_pixel((k % 2) ? 8'd255 : 8'd0, k == 0);
    wait_idle();
    // extreme taps, no division, clamp high; then negative taps with abs
    write_cfg(REG_KERN_TOP, 24'h7F7F7F);
    write_cfg(REG_KERN_MID, 24'h7F7F7F);
    write_cfg(REG_KERN_BOT, 24'h7F7F7F);
    write_cfg(REG_DIVISOR, 0);
    for (int k = 0; k < 9; k++) send_pixel(8'd255, k == 0);
    wait_idle();
    write_cfg(REG_KERN_TOP, 24'h808080);
    write_cfg(REG_KERN_MID, 24'h808080);
    write_cfg(REG_KERN_BOT, 24'h808080);
    write_cfg(REG_DIVISOR, 255);
    write_cfg(REG_ABS_MODE, 1);
    for (int k = 0; k < 9; k++) send_pixel(k == 4 ? 8'd255 : 8'd200, k == 0);
    wait_idle();

    // random phases
    prev_w = cur_w;
    cont = 1'b0;
    for (int ph = 0; items_sent < 290; ph++) begin
      stall_mode = $urandom_range(0, 3);
      gaps_on = $urandom_range(0, 3) != 0;
      write_cfg(REG_KERN_TOP, CFG_DAT_W'($urandom_range(0, 24'hFFFFFF)));
      write_cfg(REG_KERN_MID, CFG_DAT_W'($urandom_range(0, 24'hFFFFFF)));
      write_cfg(REG_KERN_BOT, CFG_DAT_W'($urandom_range(0, 24'hFFFFFF)));
      case ($urandom_range(0, 3))
        0: write_cfg(REG_DIVISOR, 0);
        1: write_cfg(REG_DIVISOR, 1);
        2: write_cfg(REG_DIVISOR, 255);
        default: write_cfg(REG_DIVISOR, CFG_DAT_W'($urandom_range(0, 255)));
      endcase
      write_cfg(REG_ABS_MODE, CFG_DAT_W'($urandom_range(0, 1)));
      if (ph == 2) begin
        // width and height both below range
        w_sel = 1;
        h_sel = 1;
      end else if (ph == 4) begin
        // height above range
        w_sel = 10;
        h_sel = 5000;
      end else begin
        w_sel = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
        case ($urandom_range(0, 7))
          0: h_sel = $urandom_range(0, 2);
          1: h_sel = $urandom_range(4096, 8191);
          default: h_sel = $urandom_range(3, 6);
        endcase
      end
      // shrinking the width without a new frame start leaves the position past it
      if (cont && $urandom_range(0, 1) && w_sel <= prev_w && w_sel >= 3) cont = 1'b1;
      else cont = 1'b0;
      write_cfg(REG_FWIDTH, CFG_DAT_W'(w_sel));
      write_cfg(REG_FHEIGHT, CFG_DAT_W'(h_sel));
      if (cur_h > 64) n = cur_w * 4 + $urandom_range(0, cur_w);
      else n = cur_w * cur_h + cur_w + $urandom_range(0, cur_w);
      if (cont) begin
        for (int k = 0; k < n; k++)
          send_pixel(8'($urandom_range(0, 255)), k > 0 && $urandom_range(0, 99) < 2);
      end else begin
        send_frames(n, $urandom_range(0, 3) == 0);
      end
      wait_idle();
      prev_w = cur_w;
      cont = 1'b1;
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+sv
sv/c3dac_pkg.sv
sv/c3dac_if.sv
sv/c3dac_mac_cell.sv
sv/c3dac_divider.sv
sv/conv3x3_divide_abs_clamp.sv
sv/c3dac_checker.sv
verif/tb_top.sv
